/* sv/bpa_pkg.sv */
// Shared constants, codes and payload types for the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int MAP_WORDS       = 128;
    localparam int PAGE_BYTES_LOG2 = 12;
    localparam int WORD_BITS       = 32;
    localparam int BIT_W           = $clog2(WORD_BITS);
    localparam int WORD_AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PG_W            = WORD_AW + BIT_W;
    localparam int RUN_W           = $clog2(MAP_WORDS * WORD_BITS + 1);
    localparam int COUNT_W         = 13;
    localparam int CMP_W           = ((RUN_W > COUNT_W) ? RUN_W : COUNT_W) + 1;
    localparam int ACTIVE_W        = $clog2(MAP_WORDS + 1);
    localparam int WORD_SHIFT      = PAGE_BYTES_LOG2 + BIT_W;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] PS_OUTSIDE = 2'd0;
    localparam logic [1:0] PS_USED    = 2'd1;
    localparam logic [1:0] PS_FREE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS_IN_USE = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        address;
        logic [COUNT_W-1:0] page_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_address;
        logic        status;
        logic [1:0]  page_state;
    } t_out_item;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] hit_bit;
        logic [RUN_W-1:0] carry_next;
    } t_scan_res;

endpackage

`default_nettype wire

/* sv/bpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire                                         i_clk,
    input  wire                                         i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                            i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/bpa_scan.sv */
// Word evaluator: extends a free-page run across one bitmap word.
`timescale 1ns / 1ps
`default_nettype none

module bpa_scan (
    input  wire  [bpa_pkg::WORD_BITS-1:0] i_word,
    input  wire  [bpa_pkg::RUN_W-1:0]     i_carry,
    input  wire  [bpa_pkg::COUNT_W-1:0]   i_count,
    output bpa_pkg::t_scan_res            o_res
);

    // z: one past the position of the last used page at or below each bit
    logic [bpa_pkg::BIT_W:0]   z    [0:bpa_pkg::BIT_W][0:bpa_pkg::WORD_BITS-1];
    logic [bpa_pkg::CMP_W-1:0] run  [0:bpa_pkg::WORD_BITS-1];
    logic [bpa_pkg::WORD_BITS-1:0] hitv;
    logic [bpa_pkg::BIT_W:0]   top;

    always_comb begin
        for (int i = 0; i < bpa_pkg::WORD_BITS; i++) begin
            z[0][i] = i_word[i] ? '0 : (bpa_pkg::BIT_W + 1)'(i + 1);
        end
        for (int l = 0; l < bpa_pkg::BIT_W; l++) begin
            for (int i = 0; i < bpa_pkg::WORD_BITS; i++) begin
                if (i >= (1 << l) && z[l][(i >= (1 << l)) ? i - (1 << l) : i] > z[l][i]) begin
                    z[l+1][i] = z[l][(i >= (1 << l)) ? i - (1 << l) : i];
                end else begin
                    z[l+1][i] = z[l][i];
                end
            end
        end
        for (int i = 0; i < bpa_pkg::WORD_BITS; i++) begin
            if (z[bpa_pkg::BIT_W][i] == '0) begin
                run[i] = bpa_pkg::CMP_W'(i_carry) + bpa_pkg::CMP_W'(i + 1);
            end else begin
                run[i] = bpa_pkg::CMP_W'(i + 1) - bpa_pkg::CMP_W'(z[bpa_pkg::BIT_W][i]);
            end
            hitv[i] = i_word[i] && (run[i] >= bpa_pkg::CMP_W'(i_count));
        end
    end

    always_comb begin
        o_res.hit     = |hitv;
        o_res.hit_bit = '0;
        for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (hitv[i]) begin
                o_res.hit_bit = bpa_pkg::BIT_W'(i);
            end
        end
        top = z[bpa_pkg::BIT_W][bpa_pkg::WORD_BITS-1];
        if (top == '0) begin
            o_res.carry_next = bpa_pkg::RUN_W'(32'(i_carry) + bpa_pkg::WORD_BITS);
        end else begin
            o_res.carry_next = bpa_pkg::RUN_W'(bpa_pkg::WORD_BITS - 32'(top));
        end
    end

endmodule

`default_nettype wire

/* sv/bitmap_page_allocator_core.sv */
// Top level of the first-fit bitmap page allocator.
//
// Usage: one transaction on the input channel (i_in_valid / o_in_stall)
// carries an operation: allocate a run of page_count pages, free the page
// holding address, or query the page holding address. Each input
// transaction yields exactly one output transaction (o_out_valid /
// i_out_stall) carrying result_address, status and page_state.
// In-region free and query pass through accept, one bitmap read and one update.
// Out-of-region free and query, zero-count allocate and unknown operations go
// straight from accept to the response. Allocate scans the bitmap words (up to
// the region size) until a run fits, then clears the words the run touches; a
// failed scan responds after the last word. The bitmap RAM has one read and one
// write port and is swept one word per cycle through a single word evaluator.
// The block takes one item at a time; o_in_stall is high while it works.
// Results sit in an output register, so a new item is accepted while a result
// waits; a finished item waits in S_RESP until the register frees. Reset makes
// every page free (per-word valid bits, no clearing pass), base_address 0 and
// words_in_use 128. Users must make configuration writes through i_cfg_we /
// i_cfg_index / i_cfg_data only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  bpa_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output bpa_pkg::t_out_item                 o_out_data,
    input  wire                                i_cfg_we,
    input  wire  [bpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [bpa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_PAGE  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic [31:0]                     r_base_address;
    logic [7:0]                      r_words_in_use;
    logic [1:0]                      r_op, n_op;
    logic [bpa_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [bpa_pkg::WORD_AW-1:0]     r_word, n_word;
    logic [bpa_pkg::BIT_W-1:0]       r_bit, n_bit;
    logic [bpa_pkg::WORD_AW-1:0]     r_scan_w, n_scan_w;
    logic [bpa_pkg::RUN_W-1:0]       r_run, n_run;
    logic [bpa_pkg::WORD_AW-1:0]     r_hit_word, n_hit_word;
    logic [bpa_pkg::BIT_W-1:0]       r_hit_bit, n_hit_bit;
    logic [bpa_pkg::PG_W-1:0]        r_start_page, n_start_page;
    logic [bpa_pkg::WORD_AW-1:0]     r_clr_w, n_clr_w;
    bpa_pkg::t_out_item              r_res, n_res;
    logic                            r_out_valid, n_out_valid;
    bpa_pkg::t_out_item              r_out_data, n_out_data;
    logic                            r_valid [0:bpa_pkg::MAP_WORDS-1];
    logic                            r_rd_valid;

    logic [bpa_pkg::ACTIVE_W-1:0]    active;
    logic [31:0]                     offset;
    logic                            in_region;
    logic [bpa_pkg::WORD_AW-1:0]     loc_word;
    logic [bpa_pkg::BIT_W-1:0]       loc_bit;
    logic [bpa_pkg::WORD_BITS-1:0]   ram_q;
    logic [bpa_pkg::WORD_BITS-1:0]   rd_word;
    logic                            ram_we;
    logic [bpa_pkg::WORD_AW-1:0]     ram_waddr;
    logic [bpa_pkg::WORD_BITS-1:0]   ram_wdata;
    logic [bpa_pkg::WORD_AW-1:0]     ram_raddr;
    bpa_pkg::t_scan_res              scan_res;
    logic [bpa_pkg::BIT_W-1:0]       mask_lo, mask_hi;
    logic [bpa_pkg::WORD_BITS-1:0]   clr_mask;
    logic                            accept;
    logic                            out_free;

    bpa_ram #(
        .WIDTH (bpa_pkg::WORD_BITS),
        .DEPTH (bpa_pkg::MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    bpa_scan u_scan (
        .i_word  (rd_word),
        .i_carry (r_run),
        .i_count (r_count),
        .o_res   (scan_res)
    );

    assign rd_word    = r_rd_valid ? ram_q : '1;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        if (32'(r_words_in_use) > 32'(bpa_pkg::MAP_WORDS)) begin
            active = bpa_pkg::ACTIVE_W'(bpa_pkg::MAP_WORDS);
        end else begin
            active = bpa_pkg::ACTIVE_W'(r_words_in_use);
        end
        offset    = i_in_data.address - r_base_address;
        in_region = (offset >> bpa_pkg::WORD_SHIFT) < 32'(active);
        loc_word  = offset[bpa_pkg::WORD_SHIFT +: bpa_pkg::WORD_AW];
        loc_bit   = offset[bpa_pkg::PAGE_BYTES_LOG2 +: bpa_pkg::BIT_W];
    end

    always_comb begin
        mask_lo  = (r_clr_w == r_start_page[bpa_pkg::PG_W-1:bpa_pkg::BIT_W])
                 ? r_start_page[bpa_pkg::BIT_W-1:0] : '0;
        mask_hi  = (r_clr_w == r_hit_word) ? r_hit_bit : '1;
        clr_mask = ({bpa_pkg::WORD_BITS{1'b1}} << mask_lo)
                 & ({bpa_pkg::WORD_BITS{1'b1}} >> (~mask_hi));
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_count      = r_count;
        n_word       = r_word;
        n_bit        = r_bit;
        n_scan_w     = r_scan_w;
        n_run        = r_run;
        n_hit_word   = r_hit_word;
        n_hit_bit    = r_hit_bit;
        n_start_page = r_start_page;
        n_clr_w      = r_clr_w;
        n_res        = r_res;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;
        ram_waddr    = r_word;
        ram_wdata    = rd_word;
        ram_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                ram_raddr = (i_in_data.operation == bpa_pkg::OP_ALLOC) ? '0 : loc_word;
                if (accept) begin
                    n_op                 = i_in_data.operation;
                    n_count              = i_in_data.page_count;
                    n_word               = loc_word;
                    n_bit                = loc_bit;
                    n_scan_w             = '0;
                    n_run                = '0;
                    n_res.result_address = '0;
                    n_res.status         = 1'b1;
                    n_res.page_state     = bpa_pkg::PS_OUTSIDE;
                    n_state              = S_RESP;
                    if (i_in_data.operation == bpa_pkg::OP_ALLOC) begin
                        if (i_in_data.page_count != '0 && active != '0) begin
                            n_state = S_SCAN;
                        end
                    end else if (i_in_data.operation == bpa_pkg::OP_FREE ||
                                 i_in_data.operation == bpa_pkg::OP_QUERY) begin
                        if (in_region) begin
                            n_state = S_PAGE;
                        end
                    end
                end
            end
            S_SCAN: begin
                ram_raddr = r_scan_w + 1'b1;
                if (scan_res.hit) begin
                    n_hit_word = r_scan_w;
                    n_hit_bit  = scan_res.hit_bit;
                    n_state    = S_FIND;
                end else if (32'(r_scan_w) + 32'd1 == 32'(active)) begin
                    n_state = S_RESP;
                end else begin
                    n_scan_w = r_scan_w + 1'b1;
                    n_run    = scan_res.carry_next;
                end
            end
            S_FIND: begin
                n_start_page = bpa_pkg::PG_W'(32'({r_hit_word, r_hit_bit}) + 32'd1
                                              - 32'(r_count));
                n_clr_w      = n_start_page[bpa_pkg::PG_W-1:bpa_pkg::BIT_W];
                ram_raddr    = n_start_page[bpa_pkg::PG_W-1:bpa_pkg::BIT_W];
                n_state      = S_CLEAR;
            end
            S_CLEAR: begin
                ram_we               = 1'b1;
                ram_waddr            = r_clr_w;
                ram_wdata            = rd_word & ~clr_mask;
                ram_raddr            = r_clr_w + 1'b1;
                n_res.result_address = r_base_address
                                     + (32'(r_start_page) << bpa_pkg::PAGE_BYTES_LOG2);
                n_res.status         = 1'b0;
                if (r_clr_w == r_hit_word) begin
                    n_state = S_RESP;
                end else begin
                    n_clr_w = r_clr_w + 1'b1;
                end
            end
            S_PAGE: begin
                n_res.status = 1'b0;
                if (r_op == bpa_pkg::OP_FREE) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_word;
                    ram_wdata = rd_word | (bpa_pkg::WORD_BITS'(1) << r_bit);
                end else begin
                    n_res.page_state = rd_word[r_bit] ? bpa_pkg::PS_FREE : bpa_pkg::PS_USED;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_base_address <= '0;
            r_words_in_use <= 8'd128;
            for (int i = 0; i < bpa_pkg::MAP_WORDS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bpa_pkg::CFG_BASE_ADDRESS: r_base_address <= i_cfg_data;
                    bpa_pkg::CFG_WORDS_IN_USE: r_words_in_use <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_count      <= n_count;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_scan_w     <= n_scan_w;
        r_run        <= n_run;
        r_hit_word   <= n_hit_word;
        r_hit_bit    <= n_hit_bit;
        r_start_page <= n_start_page;
        r_clr_w      <= n_clr_w;
        r_res        <= n_res;
        r_out_data   <= n_out_data;
        r_rd_valid   <= r_valid[ram_raddr];
    end

    a_scan_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> 32'(r_scan_w) < 32'(active))
        else $error("scan past region end");

    a_clear_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> r_clr_w <= r_hit_word)
        else $error("clear past run end");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.result_address == '0)
        else $error("failed transaction carries an address");

    a_state_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.page_state != bpa_pkg::PS_OUTSIDE
        |-> !o_out_data.status)
        else $error("page state reported with error status");

endmodule

`default_nettype wire

/* tb/bitmap_page_allocator_core_tb.sv */
// Self-checking testbench for the first-fit bitmap page allocator core.
`timescale 1ns / 1ps

module bitmap_page_allocator_core_tb;
    import bpa_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_LEN    = 700;
    localparam int         STUCK_LIMIT = 20000;
    localparam int         SETTLE      = 2 * MAP_WORDS + 40;

    logic                  i_clk       = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in_item              in_data     = '0;
    logic                  out_stall   = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;

    // Predictor state
    logic [WORD_BITS-1:0]  page_map [MAP_WORDS];
    logic [31:0]           cfg_base    = '0;
    logic [7:0]            cfg_words   = 8'd128;

    t_in_item              req_backlog [$];
    t_out_item             replies_due [$];
    int                    mismatches  = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_tokens = 0;
    int                    holds_done  = 0;
    int                    hold_left   = 0;
    int                    stuck       = 0;

    bitmap_page_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned active_words();
        return (cfg_words > MAP_WORDS) ? MAP_WORDS : cfg_words;
    endfunction

    function automatic bit locate_page(input logic [31:0] addr, output int unsigned pg);
        logic [31:0]       offset;
        longint unsigned   span_bytes;
        offset     = addr - cfg_base;
        span_bytes = active_words();
        span_bytes = (span_bytes * WORD_BITS) << PAGE_BYTES_LOG2;
        pg         = offset >> PAGE_BYTES_LOG2;
        return offset < span_bytes;
    endfunction

    function automatic t_out_item serve_request(input t_in_item req);
        t_out_item   r;
        int unsigned total;
        int unsigned run;
        int unsigned start_pg;
        int unsigned pg;
        r        = '0;
        r.status = 1'b1;
        total    = active_words() * WORD_BITS;
        case (req.operation)
            OP_ALLOC: begin
                run      = 0;
                start_pg = 0;
                if (req.page_count != 0) begin
                    for (pg = 0; pg < total; pg++) begin
                        if (!page_map[pg / WORD_BITS][pg % WORD_BITS]) begin
                            run = 0;
                        end else begin
                            if (run == 0) start_pg = pg;
                            run++;
                            if (run == req.page_count) begin
                                for (int q = start_pg; q <= pg; q++)
                                    page_map[q / WORD_BITS][q % WORD_BITS] = 1'b0;
                                r.result_address = cfg_base + (start_pg << PAGE_BYTES_LOG2);
                                r.status         = 1'b0;
                                break;
                            end
                        end
                    end
                end
            end
            OP_FREE: begin
                if (locate_page(req.address, pg)) begin
                    page_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b1;
                    r.status = 1'b0;
                end
            end
            OP_QUERY: begin
                if (locate_page(req.address, pg)) begin
                    r.page_state = page_map[pg / WORD_BITS][pg % WORD_BITS] ? PS_FREE : PS_USED;
                    r.status     = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Mostly in-region frees and queries plus small allocations; some noise.
    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned pick;
        int unsigned sz;
        int unsigned span;
        pick         = $urandom_range(0, 99);
        span         = active_words() * WORD_BITS;
        r.operation  = OP_QUERY;
        r.address    = $urandom;
        r.page_count = COUNT_W'($urandom);
        if (pick < 30) begin
            r.operation = OP_ALLOC;
            sz = $urandom_range(0, 99);
            if (sz < 3)
                r.page_count = '0;
            else if (sz < 20 && sz >= 8)
                r.page_count = COUNT_W'($urandom_range(1, 64));
            else if (sz >= 20)
                r.page_count = COUNT_W'($urandom_range(1, 8));
        end else if (pick < 85 && span != 0) begin
            r.operation = (pick < 65) ? OP_FREE : OP_QUERY;
            r.address   = cfg_base + ($urandom_range(0, span - 1) << PAGE_BYTES_LOG2)
                        + $urandom_range(0, (1 << PAGE_BYTES_LOG2) - 1);
        end else if (pick < 95) begin
            r.operation = pick[0] ? OP_FREE : OP_QUERY;
        end else begin
            r.operation = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic push_req(input logic [1:0] op, input logic [31:0] addr,
                            input logic [COUNT_W-1:0] cnt);
        t_in_item r;
        r.operation  = op;
        r.address    = addr;
        r.page_count = cnt;
        req_backlog.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_BASE_ADDRESS)
            cfg_base = val;
        else
            cfg_words = val[7:0];
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || in_valid || replies_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        @(negedge i_clk);
        repeat (n) req_backlog.push_back(random_request());
        drain();
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Sender
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= req_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_tokens) begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_LEN;
            holds_done <= holds_done + 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: check the result transaction, then predict the request transaction
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("result with no request outstanding: result_address %h",
                           o_out_data.result_address);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_out_data.result_address !== want.result_address) begin
                        $error("result_address: expected %h, got %h",
                               want.result_address, o_out_data.result_address);
                        mismatches++;
                    end
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, o_out_data.status);
                        mismatches++;
                    end
                    if (o_out_data.page_state !== want.page_state) begin
                        $error("page_state: expected %0d, got %0d",
                               want.page_state, o_out_data.page_state);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !o_in_stall)
                replies_due.push_back(serve_request(in_data));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_LIMIT) begin
            $display("bitmap_page_allocator_core_tb: FAIL");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        for (int w = 0; w < MAP_WORDS; w++)
            page_map[w] = '1;
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        set_idle(37, 75);
        @(negedge i_clk);
        push_req(OP_QUERY, 32'h0000_0000, 13'd0);
        push_req(OP_ALLOC, 32'h0000_0000, 13'd0);
        push_req(OP_ALLOC, 32'h0000_0000, 13'd1);
        push_req(OP_QUERY, 32'h0000_0ABC, 13'd0);
        push_req(OP_ALLOC, 32'h0000_0000, 13'd4096);
        push_req(OP_FREE,  32'h0000_0FFF, 13'd0);
        push_req(OP_ALLOC, 32'h0000_0000, 13'd4096);
        push_req(OP_ALLOC, 32'h0000_0000, 13'd1);
        push_req(OP_QUERY, 32'h00FF_FFFF, 13'd0);
        push_req(OP_QUERY, 32'h0100_0000, 13'd0);
        push_req(OP_FREE,  32'hFFFF_FFFF, 13'd0);
        push_req(OP_UNUSED, 32'hFFFF_FFFF, 13'h1FFF);
        push_req(OP_ALLOC, 32'hFFFF_FFFF, 13'h1FFF);
        push_req(OP_FREE,  32'd31 << PAGE_BYTES_LOG2, 13'd0);
        push_req(OP_FREE,  32'd32 << PAGE_BYTES_LOG2, 13'd0);
        push_req(OP_FREE,  32'd35 << PAGE_BYTES_LOG2, 13'd0);
        push_req(OP_FREE,  32'd36 << PAGE_BYTES_LOG2, 13'd0);
        push_req(OP_FREE,  32'd37 << PAGE_BYTES_LOG2, 13'd0);
        push_req(OP_ALLOC, 32'h0000_0000, 13'd3);
        push_req(OP_ALLOC, 32'h0000_0000, 13'd2);
        push_req(OP_FREE,  32'd63 << PAGE_BYTES_LOG2, 13'd0);
        push_req(OP_FREE,  32'd96 << PAGE_BYTES_LOG2, 13'd0);
        push_req(OP_ALLOC, 32'h0000_0000, 13'd2);
        push_req(OP_QUERY, 32'd96 << PAGE_BYTES_LOG2, 13'd0);
        push_req(OP_FREE,  32'd96 << PAGE_BYTES_LOG2, 13'd0);
        drain();

        // region that wraps past the top of the address space
        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_E000);
        write_reg(CFG_WORDS_IN_USE, 32'd4);
        run_random(500);

        write_reg(CFG_BASE_ADDRESS, $urandom);
        write_reg(CFG_WORDS_IN_USE, 32'd1);
        run_random(300);

        set_idle(75, 37);
        write_reg(CFG_WORDS_IN_USE, 32'd0);
        run_random(60);

        write_reg(CFG_BASE_ADDRESS, 32'h0000_0000);
        write_reg(CFG_WORDS_IN_USE, 32'd255);
        run_random(250);

        set_idle(0, 0);
        write_reg(CFG_BASE_ADDRESS, $urandom);
        write_reg(CFG_WORDS_IN_USE, 32'd8);
        @(negedge i_clk);
        hold_tokens = hold_tokens + 1;
        run_random(500);

        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_WORDS_IN_USE, 32'd16);
        run_random(400);

        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0)
            $display("bitmap_page_allocator_core_tb: PASS");
        else
            $display("bitmap_page_allocator_core_tb: FAIL");
        $finish;
    end

endmodule
